// File: hdl/ial_pkg.sv
// Shared types and constants for the indexed array list.
// No dependencies; imported by every module of the block.
package ial_pkg;

    // Fixed field widths of the request and result items
    localparam int KIND_W  = 3;
    localparam int POS_W   = 11;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 11;

    // Request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND = 3'd0,
        KIND_INSERT = 3'd1,
        KIND_REMOVE = 3'd2,
        KIND_READ   = 3'd3,
        KIND_WRITE  = 3'd4,
        KIND_CLEAR  = 3'd5
    } t_kind;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_FIX,
        S_RESP
    } t_state;

    // One finished result from the controller
    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        t_status                  status;
        logic [COUNT_W-1:0]       count;
    } t_result;

endpackage

// File: hdl/ial_mem.sv
// Entry store: one write port and one read port, registered read data.
// Depends on ial_pkg for the word width.
module ial_mem
    import ial_pkg::*;
#(
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/ial_ctrl.sv
// Request sequencer: decodes kinds, checks positions, runs the shift loops
// through the entry store and holds the length. Depends on ial_pkg.
module ial_ctrl
    import ial_pkg::*;
#(
    parameter int CAPACITY = 1024,
    localparam int AW = $clog2(CAPACITY)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [KIND_W-1:0]        i_kind,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [DATA_W-1:0] i_item_value,
    output logic                     o_res_valid,
    input  logic                     i_res_ready,
    output t_result                  o_res,
    output logic                     o_mem_we,
    output logic [AW-1:0]            o_mem_waddr,
    output logic [DATA_W-1:0]        o_mem_wdata,
    output logic                     o_mem_re,
    output logic [AW-1:0]            o_mem_raddr,
    input  logic [DATA_W-1:0]        i_mem_rdata
);

    localparam logic [COUNT_W-1:0] CAP_C = COUNT_W'(CAPACITY);

    t_state             r_state, n_state;
    t_kind              r_kind, n_kind;
    t_status            r_status, n_status;
    logic               r_dir_up, n_dir_up;
    logic [AW-1:0]      r_pos, n_pos;
    logic [DATA_W-1:0]  r_val, n_val;
    logic [AW-1:0]      r_rd_addr, n_rd_addr;
    logic [AW-1:0]      r_wr_addr, n_wr_addr;
    logic [COUNT_W-1:0] r_left, n_left;
    logic [COUNT_W-1:0] r_count, n_count;

    t_kind              w_kind;
    logic               w_accept;
    logic               w_full;
    logic               w_pos_ok;
    logic               w_pos_ok_ins;
    logic [COUNT_W-1:0] w_count_m1;
    logic [COUNT_W-1:0] w_ins_moves;
    logic [COUNT_W-1:0] w_rem_moves;
    logic [COUNT_W-1:0] w_pos_p1;

    // Request decode and range checks
    assign w_kind       = t_kind'(i_kind);
    assign w_accept     = i_in_valid && (r_state == S_IDLE);
    assign w_full       = (r_count >= CAP_C);
    assign w_pos_ok     = (i_position < r_count);
    assign w_pos_ok_ins = (i_position <= r_count);
    assign w_count_m1   = r_count - COUNT_W'(1);
    assign w_ins_moves  = r_count - i_position;
    assign w_rem_moves  = w_count_m1 - i_position;
    assign w_pos_p1     = i_position + COUNT_W'(1);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_RESP;
                    case (w_kind)
                        KIND_INSERT: begin
                            if (w_pos_ok_ins && !w_full && (w_ins_moves != '0)) begin
                                n_state = S_SHIFT;
                            end
                        end
                        KIND_REMOVE: begin
                            if (w_pos_ok && (w_rem_moves != '0)) begin
                                n_state = S_SHIFT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SHIFT: begin
                if (r_left == COUNT_W'(1)) begin
                    n_state = r_dir_up ? S_RESP : S_FIX;
                end
            end
            S_FIX:  n_state = S_RESP;
            S_RESP: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and store access
    always_comb begin
        n_kind      = r_kind;
        n_status    = r_status;
        n_dir_up    = r_dir_up;
        n_pos       = r_pos;
        n_val       = r_val;
        n_rd_addr   = r_rd_addr;
        n_wr_addr   = r_wr_addr;
        n_left      = r_left;
        n_count     = r_count;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_wr_addr;
        o_mem_wdata = i_mem_rdata;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_rd_addr;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_kind   = w_kind;
                    n_status = ST_OK;
                    n_val    = i_item_value;
                    n_pos    = i_position[AW-1:0];
                    case (w_kind)
                        KIND_APPEND: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = r_count[AW-1:0];
                                o_mem_wdata = i_item_value;
                                n_count     = r_count + COUNT_W'(1);
                            end
                        end
                        KIND_INSERT: begin
                            if (!w_pos_ok_ins) begin
                                n_status = ST_BAD_INDEX;
                            end else if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_count = r_count + COUNT_W'(1);
                                if (w_ins_moves == '0) begin
                                    // insert at the tail: no entries to move
                                    o_mem_we    = 1'b1;
                                    o_mem_waddr = i_position[AW-1:0];
                                    o_mem_wdata = i_item_value;
                                end else begin
                                    // move entries up, starting from the last one
                                    o_mem_re    = 1'b1;
                                    o_mem_raddr = w_count_m1[AW-1:0];
                                    n_rd_addr   = w_count_m1[AW-1:0];
                                    n_wr_addr   = r_count[AW-1:0];
                                    n_left      = w_ins_moves;
                                    n_dir_up    = 1'b0;
                                end
                            end
                        end
                        KIND_REMOVE: begin
                            if (!w_pos_ok) begin
                                n_status = ST_BAD_INDEX;
                            end else begin
                                n_count = w_count_m1;
                                if (w_rem_moves != '0) begin
                                    // move entries down, starting above the hole
                                    o_mem_re    = 1'b1;
                                    o_mem_raddr = w_pos_p1[AW-1:0];
                                    n_rd_addr   = w_pos_p1[AW-1:0];
                                    n_wr_addr   = i_position[AW-1:0];
                                    n_left      = w_rem_moves;
                                    n_dir_up    = 1'b1;
                                end
                            end
                        end
                        KIND_READ: begin
                            if (!w_pos_ok) begin
                                n_status = ST_BAD_INDEX;
                            end else begin
                                o_mem_re    = 1'b1;
                                o_mem_raddr = i_position[AW-1:0];
                            end
                        end
                        KIND_WRITE: begin
                            if (!w_pos_ok) begin
                                n_status = ST_BAD_INDEX;
                            end else begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = i_position[AW-1:0];
                                o_mem_wdata = i_item_value;
                            end
                        end
                        KIND_CLEAR: n_count = '0;
                        default: ;
                    endcase
                end
            end
            S_SHIFT: begin
                // write the entry read last cycle, fetch the next one
                o_mem_we    = 1'b1;
                o_mem_waddr = r_wr_addr;
                o_mem_wdata = i_mem_rdata;
                n_wr_addr   = r_dir_up ? (r_wr_addr + AW'(1)) : (r_wr_addr - AW'(1));
                n_left      = r_left - COUNT_W'(1);
                if (r_left != COUNT_W'(1)) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_dir_up ? (r_rd_addr + AW'(1)) : (r_rd_addr - AW'(1));
                    n_rd_addr   = o_mem_raddr;
                end
            end
            S_FIX: begin
                // drop the new value into the opened slot
                o_mem_we    = 1'b1;
                o_mem_waddr = r_pos;
                o_mem_wdata = r_val;
            end
            S_RESP: ;
            default: ;
        endcase
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_status  <= n_status;
        r_dir_up  <= n_dir_up;
        r_pos     <= n_pos;
        r_val     <= n_val;
        r_rd_addr <= n_rd_addr;
        r_wr_addr <= n_wr_addr;
        r_left    <= n_left;
    end

    // Handshake and result
    assign o_in_ready       = (r_state == S_IDLE);
    assign o_res_valid      = (r_state == S_RESP);
    assign o_res.read_value = ((r_kind == KIND_READ) && (r_status == ST_OK))
                              ? $signed(i_mem_rdata) : '0;
    assign o_res.status     = r_status;
    assign o_res.count      = r_count;

`ifndef SYNTHESIS
    a_shift_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_left != '0))
        else $error("shift loop running with no moves left");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem_we && o_mem_re) |-> (o_mem_waddr != o_mem_raddr))
        else $error("read and write hit the same entry in one cycle");
    a_ins_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && r_left == COUNT_W'(1) && !r_dir_up) |=> (r_state == S_FIX))
        else $error("insert shift did not end with the slot write");
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_count <= CAP_C))
        else $error("length beyond capacity");
`endif

endmodule

// File: hdl/indexed_array_list.sv
// Sequence: append, read, write, clear, refused requests, insert at the tail and remove of
// the last entry go from accept straight to the result state; an insert that moves entries
// runs the shift loop and then the slot write, a remove that moves entries runs the shift loop.
// Throughput: one item at a time, one entry moved per cycle; the next item is taken only
// after the result of the last one has moved into the output register.
// Reset: synchronous, active low; clears the length, state and output valid, not the store.
module indexed_array_list
    import ial_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [KIND_W-1:0]        i_kind,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [DATA_W-1:0] i_item_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_read_value,
    output logic [1:0]               o_status,
    output logic [COUNT_W-1:0]       o_count,
    output logic                     o_is_empty
);

    localparam int AW = $clog2(CAPACITY);

    logic              w_mem_we;
    logic [AW-1:0]     w_mem_waddr;
    logic [DATA_W-1:0] w_mem_wdata;
    logic              w_mem_re;
    logic [AW-1:0]     w_mem_raddr;
    logic [DATA_W-1:0] w_mem_rdata;
    logic              w_res_valid;
    logic              w_res_ready;
    t_result           w_res;

    logic              r_out_valid;
    t_result           r_out;

    ial_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_position   (i_position),
        .i_item_value (i_item_value),
        .o_res_valid  (w_res_valid),
        .i_res_ready  (w_res_ready),
        .o_res        (w_res),
        .o_mem_we     (w_mem_we),
        .o_mem_waddr  (w_mem_waddr),
        .o_mem_wdata  (w_mem_wdata),
        .o_mem_re     (w_mem_re),
        .o_mem_raddr  (w_mem_raddr),
        .i_mem_rdata  (w_mem_rdata)
    );

    ial_mem #(
        .DEPTH (CAPACITY)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // Output register: takes a result when empty or being drained
    assign w_res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out.read_value;
    assign o_status     = r_out.status;
    assign o_count      = r_out.count;
    assign o_is_empty   = (r_out.count == '0);

endmodule
